@@ hw/rtl/bdac_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the binary to decimal ascii converter
package bdac_pkg;

   localparam int BcdDigits = 10;
   localparam int IdxW      = 4;
   localparam int DdSteps   = 32;
   localparam int StepW     = 5;

   localparam logic [5:0] AsciiZero = 6'd48;

   typedef logic [3:0] nibble_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIZE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic step;
   } cell_ctrl_type;

endpackage

@@ hw/rtl/bdac_cell.sv @@
`timescale 1ns / 1ps
// one bcd digit cell: add-3 correction and one-bit shift toward the next digit
module bdac_cell (
   input  logic                   clock,
   input  bdac_pkg::cell_ctrl_type ctrl,
   input  logic                   shift_in,
   output logic                   carry_out,
   output bdac_pkg::nibble_type   digit
);

   bdac_pkg::nibble_type nib_ff;
   bdac_pkg::nibble_type nib_in;
   bdac_pkg::nibble_type adj;

   always_comb begin
      adj = (nib_ff >= 4'd5) ? nib_ff + 4'd3 : nib_ff;
      carry_out = adj[3];
      nib_in = nib_ff;
      if (ctrl.clear) begin
         nib_in = '0;
      end else if (ctrl.step) begin
         nib_in = {adj[2:0], shift_in};
      end
   end

   always_ff @(posedge clock) begin
      nib_ff <= nib_in;
   end

   assign digit = nib_ff;

endmodule

@@ hw/rtl/bdac_chain.sv @@
`timescale 1ns / 1ps
// row of bcd digit cells with digit select and leading-digit search
module bdac_chain (
   input  logic                    clock,
   input  bdac_pkg::cell_ctrl_type ctrl,
   input  logic                    shift_in,
   input  logic [5:0]              read_pos,
   output bdac_pkg::nibble_type    read_digit,
   output logic [bdac_pkg::IdxW-1:0] min_len
);

   logic                 carry [bdac_pkg::BcdDigits];
   bdac_pkg::nibble_type digits [bdac_pkg::BcdDigits];

   for (genvar k = 0; k < bdac_pkg::BcdDigits; k++) begin : g_cell
      if (k == 0) begin : g_first
         bdac_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .shift_in  (shift_in),
            .carry_out (carry[k]),
            .digit     (digits[k])
         );
      end else begin : g_next
         bdac_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .shift_in  (carry[k-1]),
            .carry_out (carry[k]),
            .digit     (digits[k])
         );
      end
   end

   // positions above the top cell read as zero
   always_comb begin
      read_digit = '0;
      for (int k = 0; k < bdac_pkg::BcdDigits; k++) begin
         if (read_pos == 6'(k)) begin
            read_digit = digits[k];
         end
      end
   end

   always_comb begin
      min_len = bdac_pkg::IdxW'(1);
      for (int k = 0; k < bdac_pkg::BcdDigits; k++) begin
         if (digits[k] != '0) begin
            min_len = bdac_pkg::IdxW'(k + 1);
         end
      end
   end

endmodule

@@ hw/rtl/binary_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
// binary to decimal ascii converter: double-dabble cell row plus digit emission
// the convert steps and the size state come before the first digit is registered
// requests are taken only in idle, after the final digit of the one before is registered
// 32 double-dabble steps in the cell row, then one digit per cycle while rsp_ready holds
// a new request is taken while the final digit still waits in the output register
// reset: synchronous active high, clears the state machine and output valid
module binary_to_decimal_ascii #(
   parameter int MAX_DIGITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_value,
   input  logic [5:0]  req_digit_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_digit_char,
   output logic        rsp_last_digit
);

   localparam logic [6:0] MaxDig = 7'(MAX_DIGITS);

   bdac_pkg::state_type state_ff, state_in;
   logic [31:0]                  bin_ff, bin_in;
   logic [bdac_pkg::StepW-1:0]   step_ff, step_in;
   logic [5:0]                   count_ff, count_in;
   logic [5:0]                   pos_ff, pos_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [5:0]                   rsp_char_ff, rsp_char_in;
   logic                         rsp_last_ff, rsp_last_in;

   bdac_pkg::cell_ctrl_type      ctrl;
   bdac_pkg::nibble_type         read_digit;
   logic [bdac_pkg::IdxW-1:0]    min_len;

   bdac_chain u_chain (
      .clock      (clock),
      .ctrl       (ctrl),
      .shift_in   (bin_ff[31]),
      .read_pos   (pos_ff),
      .read_digit (read_digit),
      .min_len    (min_len)
   );

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      ctrl         = '0;
      req_ready    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         bdac_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               bin_in     = req_value;
               step_in    = '0;
               count_in   = ({1'b0, req_digit_count} > MaxDig) ? 6'(MaxDig) : req_digit_count;
               ctrl.clear = 1'b1;
               state_in   = bdac_pkg::ST_CONVERT;
            end
         end
         bdac_pkg::ST_CONVERT: begin
            ctrl.step = 1'b1;
            bin_in    = {bin_ff[30:0], 1'b0};
            step_in   = step_ff + bdac_pkg::StepW'(1);
            if (step_ff == bdac_pkg::StepW'(bdac_pkg::DdSteps - 1)) begin
               state_in = bdac_pkg::ST_SIZE;
            end
         end
         bdac_pkg::ST_SIZE: begin
            // zero count means minimal length from the highest nonzero digit
            pos_in   = (count_ff == '0) ? 6'(min_len) - 6'd1 : count_ff - 6'd1;
            state_in = bdac_pkg::ST_EMIT;
         end
         bdac_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = bdac_pkg::AsciiZero + {2'b00, read_digit};
               rsp_last_in  = (pos_ff == '0);
               pos_in       = pos_ff - 6'd1;
               if (pos_ff == '0) begin
                  state_in = bdac_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = bdac_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdac_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      step_ff     <= step_in;
      count_ff    <= count_in;
      pos_ff      <= pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;

endmodule
